### src/b64d_pkg.sv
// Shared types, character codes and status codes of the base64url stream decoder.
package b64d_pkg;

  localparam int unsigned CharWidth   = 8;
  localparam int unsigned SextetWidth = 6;
  localparam int unsigned BufWidth    = 12;
  localparam int unsigned CountWidth  = 3;

  localparam logic [CharWidth-1:0] CHAR_END     = 8'h00;
  localparam logic [CharWidth-1:0] CHAR_UPPER_A = 8'h41;
  localparam logic [CharWidth-1:0] CHAR_UPPER_Z = 8'h5A;
  localparam logic [CharWidth-1:0] CHAR_LOWER_A = 8'h61;
  localparam logic [CharWidth-1:0] CHAR_LOWER_Z = 8'h7A;
  localparam logic [CharWidth-1:0] CHAR_DIGIT_0 = 8'h30;
  localparam logic [CharWidth-1:0] CHAR_DIGIT_9 = 8'h39;
  localparam logic [CharWidth-1:0] CHAR_MINUS   = 8'h2D;
  localparam logic [CharWidth-1:0] CHAR_PLUS    = 8'h2B;
  localparam logic [CharWidth-1:0] CHAR_UNDER   = 8'h5F;
  localparam logic [CharWidth-1:0] CHAR_SLASH   = 8'h2F;
  localparam logic [CharWidth-1:0] CHAR_PAD     = 8'h3D;

  localparam logic [CharWidth-1:0] LOWER_BASE = 8'd26;
  localparam logic [CharWidth-1:0] DIGIT_BASE = 8'd52;
  localparam logic [SextetWidth-1:0] SEXTET_62 = 6'd62;
  localparam logic [SextetWidth-1:0] SEXTET_63 = 6'd63;

  localparam logic [CountWidth:0] COUNT_STEP = 4'd6;

  typedef enum logic [1:0] {
    STATUS_OK         = 2'd0,
    STATUS_BAD_CHAR   = 2'd1,
    STATUS_BAD_LENGTH = 2'd2
  } status_t;

  typedef struct packed {
    logic                   valid;
    logic                   pad;
    logic [SextetWidth-1:0] value;
  } sextet_t;

  typedef struct packed {
    logic [BufWidth-1:0]   bit_buffer;
    logic [CountWidth-1:0] bit_count;
    logic [1:0]            length_mod_four;
    logic                  pad_seen;
    logic                  bad_char_seen;
  } dec_state_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       has_byte;
    logic       end_of_text;
    status_t    status;
  } dec_result_t;

endpackage

### src/b64d_sextet_map.sv
// Character to 6-bit value map for the URL-safe and standard base64 alphabets.
module b64d_sextet_map (
  input  logic [b64d_pkg::CharWidth-1:0] text_char,
  output b64d_pkg::sextet_t              sextet
);

  logic [b64d_pkg::CharWidth-1:0] upper_off;
  logic [b64d_pkg::CharWidth-1:0] lower_off;
  logic [b64d_pkg::CharWidth-1:0] digit_off;

  assign upper_off = text_char - b64d_pkg::CHAR_UPPER_A;
  assign lower_off = text_char - b64d_pkg::CHAR_LOWER_A + b64d_pkg::LOWER_BASE;
  assign digit_off = text_char - b64d_pkg::CHAR_DIGIT_0 + b64d_pkg::DIGIT_BASE;

  always_comb begin
    sextet.valid = 1'b1;
    sextet.pad   = 1'b0;
    sextet.value = '0;
    priority if (text_char >= b64d_pkg::CHAR_UPPER_A && text_char <= b64d_pkg::CHAR_UPPER_Z) begin
      sextet.value = upper_off[b64d_pkg::SextetWidth-1:0];
    end else if (text_char >= b64d_pkg::CHAR_LOWER_A &&
                 text_char <= b64d_pkg::CHAR_LOWER_Z) begin
      sextet.value = lower_off[b64d_pkg::SextetWidth-1:0];
    end else if (text_char >= b64d_pkg::CHAR_DIGIT_0 &&
                 text_char <= b64d_pkg::CHAR_DIGIT_9) begin
      sextet.value = digit_off[b64d_pkg::SextetWidth-1:0];
    end else if (text_char == b64d_pkg::CHAR_MINUS || text_char == b64d_pkg::CHAR_PLUS) begin
      sextet.value = b64d_pkg::SEXTET_62;
    end else if (text_char == b64d_pkg::CHAR_UNDER || text_char == b64d_pkg::CHAR_SLASH) begin
      sextet.value = b64d_pkg::SEXTET_63;
    end else if (text_char == b64d_pkg::CHAR_PAD) begin
      sextet.valid = 1'b0;
      sextet.pad   = 1'b1;
    end else begin
      sextet.valid = 1'b0;
    end
  end

endmodule

### src/b64d_decode_step.sv
// Next decoder state and result for one character.
module b64d_decode_step (
  input  logic [b64d_pkg::CharWidth-1:0] text_char,
  input  b64d_pkg::sextet_t              sextet,
  input  b64d_pkg::dec_state_t           cur,
  output b64d_pkg::dec_state_t           nxt,
  output b64d_pkg::dec_result_t          result
);

  logic [b64d_pkg::BufWidth-1:0]   buf_shift;
  logic [b64d_pkg::CountWidth:0]   count_sum;
  logic [b64d_pkg::CountWidth-1:0] count_after;
  logic [b64d_pkg::BufWidth-1:0]   byte_win;

  assign buf_shift   = {cur.bit_buffer[b64d_pkg::BufWidth-b64d_pkg::SextetWidth-1:0],
                        sextet.value};
  assign count_sum   = {1'b0, cur.bit_count} + b64d_pkg::COUNT_STEP;
  assign count_after = count_sum[b64d_pkg::CountWidth-1:0];
  assign byte_win    = buf_shift >> count_after;

  always_comb begin
    nxt    = cur;
    result = '0;
    result.status = b64d_pkg::STATUS_OK;
    if (text_char == b64d_pkg::CHAR_END) begin
      result.end_of_text = 1'b1;
      priority if (cur.length_mod_four == 2'd1) begin
        result.status = b64d_pkg::STATUS_BAD_LENGTH;
      end else if (cur.bad_char_seen) begin
        result.status = b64d_pkg::STATUS_BAD_CHAR;
      end else begin
        result.status = b64d_pkg::STATUS_OK;
      end
      nxt = '0;
    end else begin
      nxt.length_mod_four = cur.length_mod_four + 2'd1;
      if (!cur.pad_seen && !cur.bad_char_seen) begin
        priority if (sextet.pad) begin
          nxt.pad_seen = 1'b1;
        end else if (!sextet.valid) begin
          nxt.bad_char_seen = 1'b1;
        end else begin
          nxt.bit_buffer = buf_shift;
          nxt.bit_count  = count_after;
          if (count_sum[b64d_pkg::CountWidth]) begin
            result.out_byte = byte_win[7:0];
            result.has_byte = 1'b1;
          end
        end
      end
    end
  end

endmodule

### src/base64url_stream_decoder_core.sv
// Top level of the base64url stream decoder: input register, decode step, result register.
// One character per item in, one result per item out, one item per cycle sustained while
// m_axis_tready is high; a character passes the input register, then the result register;
// the decoder state register is updated in the single decode stage. A zero character ends
// the text and carries status in tuser[2:1] (0 ok, 1 invalid character, 2 length one
// modulo four); bytes of a text whose status is not ok are to be discarded by the consumer.
module base64url_stream_decoder_core (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] text_char
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] out_byte
  output logic [2:0] m_axis_tuser,   // [0] has_byte, [2:1] status
  output logic       m_axis_tlast    // end_of_text
);

  logic                           in_valid;
  logic [b64d_pkg::CharWidth-1:0] in_char;
  b64d_pkg::dec_state_t           state;
  b64d_pkg::dec_state_t           state_next;
  b64d_pkg::sextet_t              sextet;
  b64d_pkg::dec_result_t          step_result;
  logic                           out_valid;
  b64d_pkg::dec_result_t          out_result;
  logic                           advance;

  assign advance       = !out_valid || m_axis_tready;
  assign s_axis_tready = !in_valid || advance;

  b64d_sextet_map u_map (
    .text_char (in_char),
    .sextet    (sextet)
  );

  b64d_decode_step u_step (
    .text_char (in_char),
    .sextet    (sextet),
    .cur       (state),
    .nxt       (state_next),
    .result    (step_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_char <= s_axis_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (in_valid && advance) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && advance) begin
      out_result <= step_result;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_result.out_byte;
  assign m_axis_tuser  = {out_result.status, out_result.has_byte};
  assign m_axis_tlast  = out_result.end_of_text;

  a_eot_no_byte: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tlast |-> !m_axis_tuser[0])
    else $error("byte flagged on end item");

  a_status_only_at_end: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tlast |-> m_axis_tuser[2:1] == b64d_pkg::STATUS_OK)
    else $error("status set on a non-end item");

  a_count_even: assert property (@(posedge clk) disable iff (rst)
    !state.bit_count[0])
    else $error("odd bit count");

  a_clear_after_end: assert property (@(posedge clk) disable iff (rst)
    in_valid && advance && in_char == b64d_pkg::CHAR_END |=> state == '0)
    else $error("state not cleared after end item");

endmodule
